@@ src/image_geometric_remap_macros.svh @@
// assertion macros for the image geometric remap block
// used by the top level only, no other dependencies
`ifndef IMAGE_GEOMETRIC_REMAP_MACROS_SVH
`define IMAGE_GEOMETRIC_REMAP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define IGR_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define IGR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IGR_ASSERT_NOW(name, clk, rst, ante, cons, msg)
`define IGR_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

@@ src/igr_pkg.sv @@
// shared types and constants for the image geometric remap block
// no dependencies; used by every module of the block
package igr_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 256;
   localparam int MAX_HEIGHT_DEFAULT = 256;

   localparam int PIXEL_W     = 24;
   localparam int MODE_W      = 3;
   localparam int DIM_REG_W   = 9;
   localparam int CORNER_W    = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = 9'd256;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDENTITY     = 3'd0,
      MODE_MIRROR_H     = 3'd1,
      MODE_MIRROR_V     = 3'd2,
      MODE_ROTATE_LEFT  = 3'd3,
      MODE_ROTATE_RIGHT = 3'd4,
      MODE_CROP         = 3'd5
   } igr_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE         = 3'd0,
      CSR_FRAME_WIDTH  = 3'd1,
      CSR_FRAME_HEIGHT = 3'd2,
      CSR_CROP_LEFT    = 3'd3,
      CSR_CROP_TOP     = 3'd4,
      CSR_CROP_WIDTH   = 3'd5,
      CSR_CROP_HEIGHT  = 3'd6
   } igr_csr_type;

   typedef enum logic {
      OP_STORE = 1'b0,
      OP_READ  = 1'b1
   } igr_op_type;

   // per-pixel status travelling from the read mapper to the result stage
   typedef struct packed {
      logic fault;
      logic last;
   } igr_rd_flags_type;

endpackage

@@ src/image_geometric_remap.sv @@
// Frame remapper: store beats load a frame in raster order, read beats return
// the flipped, rotated or cropped frame one pixel per beat. The block takes one
// beat in every clock cycle and never raises busy. A read beat's pixel comes
// out in the cycle after it is accepted, from the registered read port
// of the frame store; the receiver cannot stall, so rsp_strobe marks each
// result for a single cycle and the next beat may follow at once. Store beats
// give no result. Frame store contents are undefined after reset until
// written; reading an unwritten pixel returns whatever the memory holds.
// Depends on igr_pkg, igr_write_ctr, igr_read_map, igr_frame_store and the
// assertion macro header.
`include "image_geometric_remap_macros.svh"
module image_geometric_remap #(
   parameter int MAX_WIDTH  = igr_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = igr_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_operation,
   input  logic [igr_pkg::PIXEL_W-1:0]    req_pixel_in,
   // result channel
   output logic                           rsp_strobe,
   output logic [igr_pkg::PIXEL_W-1:0]    rsp_pixel_out,
   output logic                           rsp_last_pixel,
   output logic                           rsp_fault,
   // register write port
   input  logic                           csr_we,
   input  logic [igr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [igr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int RW     = $clog2(MAX_HEIGHT);
   localparam int MAXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_W  = $clog2(MAXD + 1);
   localparam int ADDR_W = CW + RW;

   // configuration registers
   logic [igr_pkg::MODE_W-1:0]    mode_ff;
   logic [igr_pkg::DIM_REG_W-1:0] frame_width_ff, frame_height_ff;
   logic [igr_pkg::DIM_REG_W-1:0] crop_width_ff, crop_height_ff;
   logic [igr_pkg::CORNER_W-1:0]  crop_left_ff, crop_top_ff;

   // sizes clamped to the legal range
   logic [DIM_W-1:0] frame_w, frame_h, crop_w, crop_h;

   logic accept, store_beat, read_beat;

   logic [CW-1:0] wr_col, src_col;
   logic [RW-1:0] wr_row, src_row;
   igr_pkg::igr_rd_flags_type rd_flags, flags_ff;
   logic                        valid_ff;
   logic [igr_pkg::PIXEL_W-1:0] rd_data;

   // every beat finishes in one pass, so the block is always free
   assign busy       = 1'b0;
   assign accept     = start && !busy;
   assign store_beat = accept && (req_operation == igr_pkg::OP_STORE);
   assign read_beat  = accept && (req_operation == igr_pkg::OP_READ);

   // register writes, index beyond the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= igr_pkg::MODE_IDENTITY;
         frame_width_ff  <= igr_pkg::DIM_RESET;
         frame_height_ff <= igr_pkg::DIM_RESET;
         crop_left_ff    <= '0;
         crop_top_ff     <= '0;
         crop_width_ff   <= igr_pkg::DIM_RESET;
         crop_height_ff  <= igr_pkg::DIM_RESET;
      end else if (csr_we) begin
         case (igr_pkg::igr_csr_type'(csr_index))
            igr_pkg::CSR_MODE:         mode_ff <= csr_wdata[igr_pkg::MODE_W-1:0];
            igr_pkg::CSR_FRAME_WIDTH:  frame_width_ff <= csr_wdata;
            igr_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            igr_pkg::CSR_CROP_LEFT:    crop_left_ff <= csr_wdata[igr_pkg::CORNER_W-1:0];
            igr_pkg::CSR_CROP_TOP:     crop_top_ff <= csr_wdata[igr_pkg::CORNER_W-1:0];
            igr_pkg::CSR_CROP_WIDTH:   crop_width_ff <= csr_wdata;
            igr_pkg::CSR_CROP_HEIGHT:  crop_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // zero counts as one, anything past the maximum counts as the maximum
   always_comb begin
      if (frame_width_ff == '0) frame_w = DIM_W'(1);
      else if (32'(frame_width_ff) > MAX_WIDTH) frame_w = DIM_W'(MAX_WIDTH);
      else frame_w = DIM_W'(frame_width_ff);

      if (frame_height_ff == '0) frame_h = DIM_W'(1);
      else if (32'(frame_height_ff) > MAX_HEIGHT) frame_h = DIM_W'(MAX_HEIGHT);
      else frame_h = DIM_W'(frame_height_ff);

      if (crop_width_ff == '0) crop_w = DIM_W'(1);
      else if (32'(crop_width_ff) > MAX_WIDTH) crop_w = DIM_W'(MAX_WIDTH);
      else crop_w = DIM_W'(crop_width_ff);

      if (crop_height_ff == '0) crop_h = DIM_W'(1);
      else if (32'(crop_height_ff) > MAX_HEIGHT) crop_h = DIM_W'(MAX_HEIGHT);
      else crop_h = DIM_W'(crop_height_ff);
   end

   // load position
   igr_write_ctr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DIM_W      (DIM_W)
   ) u_write_ctr (
      .clock   (clock),
      .reset   (reset),
      .advance (store_beat),
      .frame_w (frame_w),
      .frame_h (frame_h),
      .col     (wr_col),
      .row     (wr_row)
   );

   // output position and source pixel for the current mode
   igr_read_map #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DIM_W      (DIM_W)
   ) u_read_map (
      .clock     (clock),
      .reset     (reset),
      .advance   (read_beat),
      .mode      (mode_ff),
      .frame_w   (frame_w),
      .frame_h   (frame_h),
      .crop_w    (crop_w),
      .crop_h    (crop_h),
      .crop_left (crop_left_ff),
      .crop_top  (crop_top_ff),
      .src_col   (src_col),
      .src_row   (src_row),
      .flags     (rd_flags)
   );

   // row-major store, address is row and column side by side
   igr_frame_store #(
      .ADDR_W (ADDR_W)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (store_beat),
      .wr_addr ({wr_row, wr_col}),
      .wr_data (req_pixel_in),
      .rd_en   (read_beat),
      .rd_addr ({src_row, src_col}),
      .rd_data (rd_data)
   );

   // result stage lines up with the registered memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= read_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (read_beat) begin
         flags_ff <= rd_flags;
      end
   end

   assign rsp_strobe     = valid_ff;
   assign rsp_fault      = valid_ff && flags_ff.fault;
   assign rsp_last_pixel = valid_ff && flags_ff.last;
   // a crop outside the frame returns black
   assign rsp_pixel_out  = flags_ff.fault ? '0 : rd_data;

   // every read beat gives exactly one result, in the next cycle
   `IGR_ASSERT_NEXT(a_read_gives_result, clock, reset, read_beat, rsp_strobe, "read beat without result")
   `IGR_ASSERT_NOW(a_result_from_read, clock, reset, rsp_strobe, $past(read_beat), "result without read beat")
   // the fault flag only comes out of crop mode
   `IGR_ASSERT_NOW(a_fault_only_crop, clock, reset, rsp_fault, $past(mode_ff) == igr_pkg::MODE_CROP, "fault outside crop mode")

endmodule

@@ src/igr_write_ctr.sv @@
// raster write position for loading the frame store
// depends on igr_pkg for nothing but default sizes; widths from parameters
module igr_write_ctr #(
   parameter int MAX_WIDTH  = igr_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = igr_pkg::MAX_HEIGHT_DEFAULT,
   parameter int DIM_W      = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [DIM_W-1:0]              frame_w,
   input  logic [DIM_W-1:0]              frame_h,
   output logic [$clog2(MAX_WIDTH)-1:0]  col,
   output logic [$clog2(MAX_HEIGHT)-1:0] row
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [DIM_W-1:0] col_inc, row_inc;

   always_comb begin
      // stale counters after a size change restart at the origin
      col = (DIM_W'(col_ff) >= frame_w) ? '0 : col_ff;
      row = (DIM_W'(row_ff) >= frame_h) ? '0 : row_ff;
      col_inc = DIM_W'(col) + DIM_W'(1);
      row_inc = DIM_W'(row) + DIM_W'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (col_inc >= frame_w) begin
            col_in = '0;
            row_in = (row_inc >= frame_h) ? '0 : RW'(row_inc);
         end else begin
            col_in = CW'(col_inc);
            row_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ src/igr_read_map.sv @@
// read position and source coordinate mapping for each output pixel
// depends on igr_pkg for mode codes and the flags struct
module igr_read_map #(
   parameter int MAX_WIDTH  = igr_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = igr_pkg::MAX_HEIGHT_DEFAULT,
   parameter int DIM_W      = 9
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [igr_pkg::MODE_W-1:0]      mode,
   input  logic [DIM_W-1:0]                frame_w,
   input  logic [DIM_W-1:0]                frame_h,
   input  logic [DIM_W-1:0]                crop_w,
   input  logic [DIM_W-1:0]                crop_h,
   input  logic [igr_pkg::CORNER_W-1:0]    crop_left,
   input  logic [igr_pkg::CORNER_W-1:0]    crop_top,
   output logic [$clog2(MAX_WIDTH)-1:0]    src_col,
   output logic [$clog2(MAX_HEIGHT)-1:0]   src_row,
   output igr_pkg::igr_rd_flags_type       flags
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int KW   = $clog2(MAXD);
   // source coordinate width: room for corner plus counter
   localparam int XW   = ((KW > igr_pkg::CORNER_W) ? KW : igr_pkg::CORNER_W) + 1;

   logic [KW-1:0]    rc_ff, rc_in, rr_ff, rr_in, rc, rr;
   logic [DIM_W-1:0] out_w, out_h, rc_inc, rr_inc;
   logic [XW-1:0]    sx, sy, xw, xh, xrc, xrr;

   always_comb begin
      case (igr_pkg::igr_mode_type'(mode))
         igr_pkg::MODE_ROTATE_LEFT, igr_pkg::MODE_ROTATE_RIGHT: begin
            out_w = frame_h;
            out_h = frame_w;
         end
         igr_pkg::MODE_CROP: begin
            out_w = crop_w;
            out_h = crop_h;
         end
         default: begin
            out_w = frame_w;
            out_h = frame_h;
         end
      endcase

      rc = (DIM_W'(rc_ff) >= out_w) ? '0 : rc_ff;
      rr = (DIM_W'(rr_ff) >= out_h) ? '0 : rr_ff;

      xw  = XW'(frame_w);
      xh  = XW'(frame_h);
      xrc = XW'(rc);
      xrr = XW'(rr);

      case (igr_pkg::igr_mode_type'(mode))
         igr_pkg::MODE_MIRROR_H: begin
            sx = xw - XW'(1) - xrc;
            sy = xrr;
         end
         igr_pkg::MODE_MIRROR_V: begin
            sx = xrc;
            sy = xh - XW'(1) - xrr;
         end
         igr_pkg::MODE_ROTATE_LEFT: begin
            sx = xw - XW'(1) - xrr;
            sy = xrc;
         end
         igr_pkg::MODE_ROTATE_RIGHT: begin
            sx = xrr;
            sy = xh - XW'(1) - xrc;
         end
         igr_pkg::MODE_CROP: begin
            sx = XW'(crop_left) + xrc;
            sy = XW'(crop_top) + xrr;
         end
         default: begin
            sx = xrc;
            sy = xrr;
         end
      endcase

      // only a crop window can reach past the frame
      flags.fault = (sx >= xw) || (sy >= xh);
      flags.last  = (DIM_W'(rc) == out_w - DIM_W'(1)) &&
                    (DIM_W'(rr) == out_h - DIM_W'(1));
      src_col = sx[CW-1:0];
      src_row = sy[RW-1:0];

      rc_inc = DIM_W'(rc) + DIM_W'(1);
      rr_inc = DIM_W'(rr) + DIM_W'(1);
      rc_in = rc_ff;
      rr_in = rr_ff;
      if (advance) begin
         if (rc_inc >= out_w) begin
            rc_in = '0;
            rr_in = (rr_inc >= out_h) ? '0 : KW'(rr_inc);
         end else begin
            rc_in = KW'(rc_inc);
            rr_in = rr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff <= '0;
         rr_ff <= '0;
      end else begin
         rc_ff <= rc_in;
         rr_ff <= rr_in;
      end
   end

endmodule

@@ src/igr_frame_store.sv @@
// frame store: one write port, one read port with registered read data
// depends on igr_pkg for the pixel width
module igr_frame_store #(
   parameter int ADDR_W = 16
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [igr_pkg::PIXEL_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [igr_pkg::PIXEL_W-1:0] rd_data
);

   logic [igr_pkg::PIXEL_W-1:0] mem [2**ADDR_W];
   logic [igr_pkg::PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
